// ----- design/ptt_pkg.sv -----
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants for the periodic task timer bank.
// ----------------------------------------------------------------------------
package ptt_pkg;

	localparam int DEF_MAX_SLOTS = 16;
	localparam int CFG_W         = 5;
	localparam int SLOT_W        = 4;
	localparam int TIME_W        = 32;
	localparam int OP_W          = 4;

	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_ADD      = 4'd0;
	localparam op_t OP_DELETE   = 4'd1;
	localparam op_t OP_START    = 4'd2;
	localparam op_t OP_STOP     = 4'd3;
	localparam op_t OP_RUN_NOW  = 4'd4;
	localparam op_t OP_SET_INT  = 4'd5;
	localparam op_t OP_TICK     = 4'd6;
	localparam op_t OP_NEXT_ALL = 4'd7;
	localparam op_t OP_NEXT_ONE = 4'd8;
	localparam op_t OP_STATE    = 4'd9;
	localparam op_t OP_COUNT    = 4'd10;

	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] period;
		logic              flag;
		logic [TIME_W-1:0] now;
		logic              scan;
	} item_t;

	function automatic logic is_scan_op(input op_t op);
		logic r;
		case (op)
			OP_ADD, OP_TICK, OP_NEXT_ALL, OP_COUNT: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ----- design/periodic_task_timer_bank.sv -----
// ----------------------------------------------------------------------------
// periodic_task_timer_bank
// Bank of periodic timer slots with add/delete/start/stop/tick and queries.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall) takes one command transaction with the
//    current millisecond time. A two-entry queue decouples it from execution.
//  - Output channel (out_valid/out_stall) returns results; the final result
//    of a command has last set. Tick gives one fire result per due slot.
//  - cfg channel (cfg_valid/cfg_ready, always ready) writes slot_count and
//    clears all slots; write it only while the block is idle.
//  - Single-slot commands are handled in one sequencer step; add, tick,
//    next_all and count scan the table one slot per cycle while the output
//    is not stalled. The scan over the slot table sets the rate.
//  - A stalled receiver holds the output register; the sequencer waits, the
//    queue fills and in_stall rises.
//  - Reset: all slots empty, slot_count is 16 (clamped to MAX_SLOTS).
// ----------------------------------------------------------------------------
module periodic_task_timer_bank #(
	parameter int MAX_SLOTS = ptt_pkg::DEF_MAX_SLOTS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ptt_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  ptt_pkg::op_t               operation,
	input  logic [ptt_pkg::SLOT_W-1:0] slot,
	input  logic [ptt_pkg::TIME_W-1:0] period,
	input  logic                       flag,
	input  logic [ptt_pkg::TIME_W-1:0] now,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ptt_pkg::SLOT_W-1:0] handle,
	output logic                       ok,
	output logic                       fired,
	output logic [ptt_pkg::TIME_W-1:0] value,
	output logic                       last
);
	import ptt_pkg::*;

	logic  pop;
	logic  head_valid;
	item_t head;

	assign cfg_ready = 1'b1;

	ptt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.slot       (slot),
		.period     (period),
		.flag       (flag),
		.now        (now),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	ptt_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.handle     (handle),
		.ok         (ok),
		.fired      (fired),
		.value      (value),
		.last       (last)
	);

endmodule

// ----- design/ptt_front.sv -----
// ----------------------------------------------------------------------------
// ptt_front
// Input acceptance, op classification and a two-entry command queue.
// ----------------------------------------------------------------------------
module ptt_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  ptt_pkg::op_t               operation,
	input  logic [ptt_pkg::SLOT_W-1:0] slot,
	input  logic [ptt_pkg::TIME_W-1:0] period,
	input  logic                       flag,
	input  logic [ptt_pkg::TIME_W-1:0] now,
	input  logic                       pop,
	output logic                       head_valid,
	output ptt_pkg::item_t             head
);
	import ptt_pkg::*;

	item_t       mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        deq;
	item_t       new_item;

	assign in_stall   = (cnt_q == 2'd2);
	assign push       = in_valid && !in_stall;
	assign head_valid = (cnt_q != 2'd0);
	assign deq        = pop && head_valid;
	assign head       = mem_q[rd_ptr_q];

	always_comb begin
		new_item.op     = operation;
		new_item.slot   = slot;
		new_item.period = period;
		new_item.flag   = flag;
		new_item.now    = now;
		new_item.scan   = is_scan_op(operation);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (deq) rd_ptr_q <= !rd_ptr_q;
			case ({push, deq})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- design/ptt_back.sv -----
// ----------------------------------------------------------------------------
// ptt_back
// Slot table and sequencer: single-slot ops in one step, scans one slot
// per cycle unless the output stalls, results through one output register.
// ----------------------------------------------------------------------------
module ptt_back #(
	parameter int MAX_SLOTS = ptt_pkg::DEF_MAX_SLOTS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  logic [ptt_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       head_valid,
	input  ptt_pkg::item_t             head,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ptt_pkg::SLOT_W-1:0] handle,
	output logic                       ok,
	output logic                       fired,
	output logic [ptt_pkg::TIME_W-1:0] value,
	output logic                       last
);
	import ptt_pkg::*;

	localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int SW = (CW > SLOT_W) ? CW : SLOT_W;
	localparam int RST_CNT = (MAX_SLOTS < 16) ? MAX_SLOTS : 16;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SINGLE = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_DONE   = 4'b1000
	} state_t;

	state_t              state_q;
	item_t               cmd_q;
	logic [IW-1:0]       idx_q;
	logic [CW-1:0]       cnt_q;
	logic [TIME_W-1:0]   acc_q;
	logic                any_q;
	logic                pend_q;
	logic [SLOT_W-1:0]   pend_h_q;

	logic [MAX_SLOTS-1:0] occ_q;
	logic [MAX_SLOTS-1:0] en_q;
	logic [TIME_W-1:0]    intv_q [MAX_SLOTS];
	logic [TIME_W-1:0]    base_q [MAX_SLOTS];

	logic                out_valid_q;
	logic [SLOT_W-1:0]   handle_q;
	logic                ok_q;
	logic                fired_q;
	logic [TIME_W-1:0]   value_q;
	logic                last_q;

	logic              can_emit;
	logic              occ_rd;
	logic              en_rd;
	logic [TIME_W-1:0] intv_rd;
	logic [TIME_W-1:0] base_rd;
	logic              act_rd;
	logic [TIME_W-1:0] deadline;
	logic [TIME_W-1:0] tleft;
	logic              due;
	logic              slot_ok;
	logic              last_idx;
	logic [SLOT_W-1:0] idx_h;

	logic              emit;
	logic [SLOT_W-1:0] e_handle;
	logic              e_ok;
	logic              e_fired;
	logic [TIME_W-1:0] e_value;
	logic              e_last;
	logic              wr_int;
	logic              wr_base;
	logic [TIME_W-1:0] base_val;
	logic              set_occ, clr_occ, set_en, clr_en;

	assign can_emit = !out_valid_q || !out_stall;
	assign occ_rd   = occ_q[idx_q];
	assign en_rd    = en_q[idx_q];
	assign intv_rd  = intv_q[idx_q];
	assign base_rd  = base_q[idx_q];
	assign act_rd   = occ_rd && en_rd && (intv_rd != '0);
	assign deadline = base_rd + intv_rd;
	assign tleft    = (cmd_q.now >= deadline) ? '0 : (deadline - cmd_q.now);
	assign due      = (cmd_q.now - base_rd) >= intv_rd;
	assign slot_ok  = SW'(cmd_q.slot) < SW'(cnt_q);
	assign last_idx = (CW'(idx_q) + CW'(1)) == cnt_q;
	assign idx_h    = SLOT_W'(idx_q);
	assign pop      = (state_q == ST_IDLE) && head_valid;

	always_comb begin
		emit     = 1'b0;
		e_handle = '0;
		e_ok     = 1'b0;
		e_fired  = 1'b0;
		e_value  = '0;
		e_last   = 1'b1;
		wr_int   = 1'b0;
		wr_base  = 1'b0;
		base_val = cmd_q.now;
		set_occ  = 1'b0;
		clr_occ  = 1'b0;
		set_en   = 1'b0;
		clr_en   = 1'b0;
		case (state_q)
			ST_SINGLE: begin
				emit     = can_emit;
				e_handle = cmd_q.slot;
				e_ok     = slot_ok;
				case (cmd_q.op)
					OP_DELETE: clr_occ = slot_ok;
					OP_START: begin
						e_ok    = slot_ok && occ_rd;
						set_en  = e_ok;
						wr_base = e_ok;
					end
					OP_STOP: clr_en = slot_ok;
					OP_RUN_NOW: begin
						e_ok    = slot_ok && occ_rd;
						e_fired = e_ok;
						set_en  = e_ok && cmd_q.flag;
						wr_base = e_ok && cmd_q.flag;
					end
					OP_SET_INT: begin
						wr_int  = slot_ok;
						set_en  = slot_ok && cmd_q.flag && occ_rd;
						wr_base = set_en;
					end
					OP_NEXT_ONE: begin
						e_ok    = slot_ok && act_rd;
						e_value = e_ok ? tleft : '1;
					end
					OP_STATE: e_value = TIME_W'(slot_ok && act_rd);
					default: begin
						e_handle = '0;
						e_ok     = 1'b0;
					end
				endcase
				if (!can_emit) begin
					clr_occ = 1'b0;
					set_en  = 1'b0;
					clr_en  = 1'b0;
					wr_int  = 1'b0;
					wr_base = 1'b0;
				end
			end
			ST_SCAN: begin
				if (can_emit) begin
					case (cmd_q.op)
						OP_ADD: begin
							if (!occ_rd && !pend_q) begin
								set_occ = 1'b1;
								set_en  = cmd_q.flag;
								clr_en  = !cmd_q.flag;
								wr_int  = 1'b1;
								wr_base = 1'b1;
							end
						end
						OP_TICK: begin
							if (act_rd && due) begin
								wr_base  = 1'b1;
								base_val = base_rd + intv_rd;
								// earlier firing goes out now, this one is held back
								emit     = pend_q;
								e_handle = pend_h_q;
								e_ok     = 1'b1;
								e_fired  = 1'b1;
								e_last   = 1'b0;
							end
						end
						default: ;
					endcase
				end
			end
			ST_DONE: begin
				emit = can_emit;
				case (cmd_q.op)
					OP_ADD: begin
						e_handle = pend_h_q;
						e_ok     = pend_q;
					end
					OP_TICK: begin
						e_handle = pend_h_q;
						e_ok     = 1'b1;
						e_fired  = pend_q;
					end
					OP_NEXT_ALL: begin
						e_ok    = any_q;
						e_value = acc_q;
					end
					default: begin
						e_ok    = 1'b1;
						e_value = acc_q;
					end
				endcase
			end
			default: ;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			cnt_q    <= CW'(RST_CNT);
			occ_q    <= '0;
			en_q     <= '0;
			pend_q   <= 1'b0;
			any_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_data == '0) cnt_q <= CW'(1);
				else if (int'(cfg_data) > MAX_SLOTS) cnt_q <= CW'(MAX_SLOTS);
				else cnt_q <= CW'(cfg_data);
				occ_q <= '0;
				en_q  <= '0;
			end else begin
				if (set_occ) occ_q[idx_q] <= 1'b1;
				if (clr_occ) occ_q[idx_q] <= 1'b0;
				if (set_en) en_q[idx_q] <= 1'b1;
				if (clr_en) en_q[idx_q] <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						pend_q <= 1'b0;
						any_q  <= 1'b0;
						if (head.scan) begin
							idx_q   <= '0;
							state_q <= ST_SCAN;
						end else begin
							idx_q   <= IW'(head.slot);
							state_q <= ST_SINGLE;
						end
					end
				end
				ST_SINGLE: begin
					if (can_emit) state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (can_emit) begin
						if ((cmd_q.op == OP_ADD && set_occ) ||
						    (cmd_q.op == OP_TICK && wr_base)) begin
							pend_q <= 1'b1;
						end
						if (cmd_q.op == OP_NEXT_ALL && act_rd) any_q <= 1'b1;
						if (last_idx) state_q <= ST_DONE;
						else idx_q <= idx_q + IW'(1);
					end
				end
				ST_DONE: begin
					if (can_emit) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// command and accumulators
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q    <= head;
			pend_h_q <= '0;
			acc_q    <= (head.op == OP_NEXT_ALL) ? '1 : '0;
		end else if (state_q == ST_SCAN && can_emit) begin
			if (set_occ || (cmd_q.op == OP_TICK && wr_base)) pend_h_q <= idx_h;
			case (cmd_q.op)
				OP_NEXT_ALL: if (act_rd && tleft < acc_q) acc_q <= tleft;
				OP_COUNT:    if (occ_rd && (!cmd_q.flag || act_rd)) acc_q <= acc_q + 1'b1;
				default: ;
			endcase
		end
		if (wr_int) intv_q[idx_q] <= cmd_q.period;
		if (wr_base) base_q[idx_q] <= base_val;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (emit) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			handle_q <= e_handle;
			ok_q     <= e_ok;
			fired_q  <= e_fired;
			value_q  <= e_value;
			last_q   <= e_last;
		end
	end

	assign out_valid = out_valid_q;
	assign handle    = handle_q;
	assign ok        = ok_q;
	assign fired     = fired_q;
	assign value     = value_q;
	assign last      = last_q;

endmodule

// ----- design/ptt_checker.sv -----
// ----------------------------------------------------------------------------
// ptt_checker
// Port-level checks on the timer bank result channel.
// ----------------------------------------------------------------------------
module ptt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [ptt_pkg::SLOT_W-1:0] handle,
	input logic                       ok,
	input logic                       fired,
	input logic [ptt_pkg::TIME_W-1:0] value,
	input logic                       last
);
	import ptt_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(handle) && $stable(value)
		&& $stable(last))
		else $error("stalled result changed");

	a_fire_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fired |-> ok && (value == '0))
		else $error("fire result with bad ok or value");

	// only tick gives more than one result per transaction
	a_multi_fire: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> fired)
		else $error("non-final result that is not a firing");

endmodule

bind periodic_task_timer_bank ptt_checker u_ptt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.handle    (handle),
	.ok        (ok),
	.fired     (fired),
	.value     (value),
	.last      (last)
);

// ----- test/tb_periodic_task_timer_bank.sv -----
// ----------------------------------------------------------------------------
// tb_periodic_task_timer_bank
// Self-checking bench for the timer bank: queue-fed driver, clocked monitor,
// built-in slot table predictor, several slot_count settings per run.
// ----------------------------------------------------------------------------
module tb_periodic_task_timer_bank;
	import ptt_pkg::*;

	typedef struct packed {
		op_t        op;
		logic [3:0] slot;
		logic [31:0] period;
		logic       flag;
		logic [31:0] now;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  handle;
		logic        ok;
		logic        fired;
		logic [31:0] value;
		logic        last;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [4:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	op_t operation = OP_ADD;
	logic [3:0] slot = '0;
	logic [31:0] period = '0;
	logic flag = 1'b0;
	logic [31:0] now = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [3:0] handle;
	logic ok, fired, last;
	logic [31:0] value;

	periodic_task_timer_bank DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .slot(slot), .period(period), .flag(flag), .now(now),
		.out_valid(out_valid), .out_stall(out_stall),
		.handle(handle), .ok(ok), .fired(fired), .value(value), .last(last)
	);

	always #4 clk = ~clk;

	// predictor state
	int unsigned n_slots;
	logic        occ [16];
	logic        ena [16];
	logic [31:0] ivl [16];
	logic [31:0] base [16];

	cmd_t pending_cmds[$];
	res_t expected_results[$];
	int errors = 0;
	int n_results = 0;
	int n_fires = 0;
	longint cycles = 0;
	bit hold_send = 0;
	int long_hold = 0;
	bit stall_mode = 0;

	function automatic void clear_table();
		for (int i = 0; i < 16; i++) begin
			occ[i] = 0; ena[i] = 0; ivl[i] = 0; base[i] = 0;
		end
	endfunction

	function automatic bit active(int i);
		return occ[i] && ena[i] && ivl[i] != 0;
	endfunction

	function automatic logic [31:0] time_to_deadline(logic [31:0] t, int i);
		logic [31:0] dl;
		dl = base[i] + ivl[i];
		return (t >= dl) ? 32'd0 : dl - t;
	endfunction

	function automatic void push_res(logic [3:0] h, logic o, logic f, logic [31:0] v);
		res_t r;
		r = '{handle: h, ok: o, fired: f, value: v, last: 1'b0};
		expected_results.push_back(r);
	endfunction

	function automatic void predict(cmd_t c);
		bit vld, done, found;
		int s, n;
		logic [31:0] best, cnt, t;
		res_t r;
		s = c.slot;
		vld = s < n_slots;
		case (c.op)
			OP_ADD: begin
				found = 0;
				for (int i = 0; i < n_slots && !found; i++)
					if (!occ[i]) begin
						occ[i] = 1; ena[i] = c.flag; ivl[i] = c.period; base[i] = c.now;
						found = 1; push_res(4'(i), 1, 0, 0);
					end
				if (!found) push_res(0, 0, 0, 0);
			end
			OP_DELETE: begin
				if (vld) occ[s] = 0;
				push_res(4'(s), vld, 0, 0);
			end
			OP_START: begin
				done = vld && occ[s];
				if (done) begin ena[s] = 1; base[s] = c.now; end
				push_res(4'(s), done, 0, 0);
			end
			OP_STOP: begin
				if (vld) ena[s] = 0;
				push_res(4'(s), vld, 0, 0);
			end
			OP_RUN_NOW: begin
				done = vld && occ[s];
				if (done && c.flag) begin ena[s] = 1; base[s] = c.now; end
				push_res(4'(s), done, done, 0);
			end
			OP_SET_INT: begin
				if (vld) begin
					ivl[s] = c.period;
					if (c.flag && occ[s]) begin ena[s] = 1; base[s] = c.now; end
				end
				push_res(4'(s), vld, 0, 0);
			end
			OP_TICK: begin
				n = 0;
				for (int i = 0; i < n_slots; i++)
					if (active(i) && (c.now - base[i]) >= ivl[i]) begin
						base[i] = base[i] + ivl[i];
						push_res(4'(i), 1, 1, 0); n++;
					end
				if (n == 0) push_res(0, 1, 0, 0);
			end
			OP_NEXT_ALL: begin
				best = '1; found = 0;
				for (int i = 0; i < n_slots; i++)
					if (active(i)) begin
						t = time_to_deadline(c.now, i);
						if (t < best) best = t;
						found = 1;
					end
				push_res(0, found, 0, best);
			end
			OP_NEXT_ONE: begin
				done = vld && active(s);
				push_res(4'(s), done, 0,
					done ? time_to_deadline(c.now, s) : 32'hFFFF_FFFF);
			end
			OP_STATE: push_res(4'(s), vld, 0, (vld && active(s)) ? 32'd1 : 32'd0);
			OP_COUNT: begin
				cnt = 0;
				for (int i = 0; i < n_slots; i++)
					if (occ[i] && (!c.flag || active(i))) cnt++;
				push_res(0, 1, 0, cnt);
			end
			default: push_res(0, 0, 0, 0);
		endcase
		r = expected_results.pop_back();
		r.last = 1'b1;
		expected_results.push_back(r);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH result %0d: %s got %0h expected %0h", n_results, what, got, want);
		errors++;
	endtask

	// driver: bursts and gaps
	int gap = 0, burst = 0;
	always @(posedge clk) begin
		cmd_t c;
		bit sent;
		if (arst_n) begin
			sent = in_valid && !in_stall;
			if (sent) predict({operation, slot, period, flag, now});
			if (!(in_valid && in_stall)) begin
				if (gap > 0) begin
					gap--;
					if (sent) in_valid <= 1'b0;
				end else if (!hold_send && pending_cmds.size() > 0) begin
					c = pending_cmds.pop_front();
					operation <= c.op; slot <= c.slot; period <= c.period;
					flag <= c.flag; now <= c.now;
					in_valid <= 1'b1;
					if (burst > 0) burst--;
					else begin
						burst = $urandom_range(12);
						gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
					end
				end else if (sent) begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern plus long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (long_hold > 0) begin
				long_hold--;
				out_stall <= 1'b1;
			end else if ($urandom_range(40) == 0) begin
				stall_mode <= ~stall_mode;
				out_stall <= 1'b0;
			end else
				out_stall <= stall_mode ? ($urandom_range(2) != 0) : 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		res_t w;
		cycles++;
		if (cycles > 400000) begin
			$display("timeout");
			$display("end of test: mismatches");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (expected_results.size() == 0) begin
				$display("unexpected result %0d", n_results);
				errors++;
			end else begin
				w = expected_results.pop_front();
				if (fired) n_fires++;
				if (handle !== w.handle) report_mismatch("handle", handle, w.handle);
				if (ok !== w.ok) report_mismatch("ok", ok, w.ok);
				if (fired !== w.fired) report_mismatch("fired", fired, w.fired);
				if (value !== w.value) report_mismatch("value", value, w.value);
				if (last !== w.last) report_mismatch("last", last, w.last);
			end
		end
	end

	function automatic cmd_t mk(op_t o, int s, logic [31:0] p, bit f, logic [31:0] t);
		cmd_t c;
		c = '{op: o, slot: s[3:0], period: p, flag: f, now: t};
		return c;
	endfunction

	// sample at the falling edge so driver updates of this cycle are settled
	task automatic drain();
		while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
			@(negedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic write_count(logic [4:0] v);
		@(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		n_slots = (v == 0) ? 1 : (v > 16 ? 16 : v);
		clear_table();
	endtask

	// random phase: mixed traffic, weighted to add and tick, around a moving clock
	task automatic random_phase(int n, logic [31:0] t0);
		logic [31:0] t;
		int r;
		op_t o;
		t = t0;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			t = t + $urandom_range(40);
			if (r < 15) o = OP_ADD;
			else if (r < 40) o = OP_TICK;
			else if (r < 95) o = op_t'($urandom_range(10));
			else o = op_t'($urandom_range(15));
			pending_cmds.push_back(mk(o, $urandom_range(15),
				($urandom_range(9) == 0) ? $urandom : $urandom_range(60),
				$urandom_range(1), ($urandom_range(30) == 0) ? $urandom : t));
		end
	endtask

	initial begin
		n_slots = 16;
		clear_table();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// directed
		pending_cmds.push_back(mk(OP_COUNT, 0, 0, 0, 0));
		pending_cmds.push_back(mk(OP_TICK, 0, 0, 0, 5));
		pending_cmds.push_back(mk(OP_NEXT_ALL, 0, 0, 0, 5));
		pending_cmds.push_back(mk(OP_ADD, 0, 10, 1, 100));
		pending_cmds.push_back(mk(OP_ADD, 0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFF0));
		pending_cmds.push_back(mk(OP_ADD, 0, 0, 1, 0));
		pending_cmds.push_back(mk(OP_ADD, 0, 7, 0, 3));
		pending_cmds.push_back(mk(OP_NEXT_ONE, 0, 0, 0, 105));
		pending_cmds.push_back(mk(OP_NEXT_ONE, 1, 0, 0, 200));
		pending_cmds.push_back(mk(OP_NEXT_ONE, 15, 0, 0, 200));
		pending_cmds.push_back(mk(OP_NEXT_ALL, 0, 0, 0, 120));
		pending_cmds.push_back(mk(OP_TICK, 0, 0, 0, 130));
		pending_cmds.push_back(mk(OP_START, 3, 0, 0, 130));
		pending_cmds.push_back(mk(OP_START, 9, 0, 0, 130));
		pending_cmds.push_back(mk(OP_RUN_NOW, 3, 0, 1, 140));
		pending_cmds.push_back(mk(OP_RUN_NOW, 9, 0, 1, 140));
		pending_cmds.push_back(mk(OP_SET_INT, 2, 4, 1, 150));
		pending_cmds.push_back(mk(OP_SET_INT, 12, 4, 1, 150));
		pending_cmds.push_back(mk(OP_STATE, 2, 0, 0, 150));
		pending_cmds.push_back(mk(OP_STOP, 0, 0, 0, 150));
		pending_cmds.push_back(mk(OP_COUNT, 0, 0, 1, 150));
		pending_cmds.push_back(mk(OP_DELETE, 1, 0, 0, 150));
		pending_cmds.push_back(mk(OP_COUNT, 0, 0, 0, 150));
		pending_cmds.push_back(mk(op_t'(4'd15), 5, 3, 1, 150));
		pending_cmds.push_back(mk(op_t'(4'd11), 0, 0, 0, 0));
		drain();

		write_count(5'd1);
		random_phase(40, 32'd1000);
		drain();
		write_count(5'd0);
		random_phase(20, 32'hFFFF_FF00);
		drain();
		write_count(5'd31);
		random_phase(60, 32'hFFFF_FE00);
		// hold the receiver long while items keep coming
		long_hold = 300;
		random_phase(40, 32'd5000);
		drain();
		write_count(5'd16);
		random_phase(80, 32'd20000);
		// sender pause until every result is back
		hold_send = 1;
		while (expected_results.size() > 0 || in_valid) @(negedge clk);
		repeat (5) @(posedge clk);
		write_count(5'd5);
		hold_send = 0;
		random_phase(60, 32'd70000);
		drain();
		write_count(5'd16);
		random_phase(60, 32'd123456);
		drain();

		$display("covered %0d results, %0d fires, slot counts 1/16/5 and saturated",
			n_results, n_fires);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

// ----- periodic_task_timer_bank.f -----
design/ptt_pkg.sv
design/ptt_front.sv
design/ptt_back.sv
design/periodic_task_timer_bank.sv
design/ptt_checker.sv
test/tb_periodic_task_timer_bank.sv
